[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that an antecedent implies a consequence in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that an antecedent implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/trlt_pkg.sv]
// Package: types and constants of the request latency tracker
package trlt_pkg;

    localparam int FLOW_SLOTS = 4096;
    localparam int SLOT_W     = $clog2(FLOW_SLOTS);
    localparam int KEY_W      = 48;

    localparam logic [1:0] KIND_NEW_OPEN    = 2'd0;
    localparam logic [1:0] KIND_NEW_CLOSED  = 2'd1;
    localparam logic [1:0] KIND_CLOSE_OPEN  = 2'd2;
    localparam logic [1:0] KIND_CLOSE_CLOSED = 2'd3;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic        syn_flag;
        logic        rst_flag;
        logic        fin_flag;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [15:0] payload_len;
        logic [31:0] timestamp_ms;
    } pkt_in_t;

    typedef struct packed {
        logic        fin_ack_latency_valid;
        logic [31:0] fin_ack_latency_ms;
        logic        other_latency_valid;
        logic [31:0] other_latency_ms;
        logic [1:0]  other_latency_kind;
        logic        flow_created;
        logic        flow_closed;
        logic        flow_dropped;
        logic [63:0] total_requests;
        logic [63:0] total_time_ms;
    } pkt_out_t;

    // One flow-table entry (valid bit held separately)
    typedef struct packed {
        logic [KEY_W-1:0] entry_key;
        logic        first_request_done;
        logic [31:0] syn_time;
        logic [31:0] last_empty_ack;
        logic [31:0] last_empty_seq;
        logic [31:0] request_ack;
        logic [31:0] request_start;
        logic [31:0] response_end;
        logic [31:0] last_seen;
    } flow_entry_t;

    localparam int ENTRY_W = $bits(flow_entry_t);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_OUT
    } trlt_state_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [KEY_W-1:0] key);
        logic [15:0] f;
        f = key[15:0] ^ key[31:16] ^ key[47:32];
        return SLOT_W'(f);
    endfunction

endpackage

[hw/rtl/trlt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read
module trlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/tcp_request_latency_tracker.sv]
// Top level: per-flow TCP request/response latency tracker
//
// Usage:
//   in  channel (in_valid/in_ready/in_data): one parsed client packet per beat.
//   out channel (out_valid/out_ready/out_data): one result beat per packet,
//   carrying up to two latencies, flow event flags and the running totals.
// Timing:
//   A packet is accepted in IDLE, and its slot is read from the flow table at the
//   accepting edge (synchronous RAM, registered read); in LOOKUP the entry is
//   updated and written back while the result is loaded into the output
//   register. The result beat is valid from the edge after the accepting edge,
//   in OUT, and the next packet is accepted only after that beat is taken, so each
//   packet passes IDLE, LOOKUP and OUT in turn, set by the single read/modify/write
//   pass over the flow table memory.
//   Only one packet is in flight, so the same slot never sees overlapping access.
// Reset:
//   Valid bits live in a second RAM. After reset the block sweeps every slot,
//   one per cycle, clearing its valid bit; in_ready stays low until all
//   FLOW_SLOTS (4096) slots are clear. Totals reset to zero.
// Stall:
//   When out_ready is low the result holds in the output register; a new
//   packet is accepted only once the previous beat has been taken.
module tcp_request_latency_tracker
    import trlt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pkt_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pkt_out_t out_data
);
`include "assert_macros.svh"

    trlt_state_t       state_reg, state_next;
    logic [SLOT_W:0]   clr_reg, clr_next;
    pkt_in_t           pkt_reg, pkt_next;
    pkt_out_t          res_reg, res_next;
    logic [63:0]       cnt_reg, cnt_next;
    logic [63:0]       sum_reg, sum_next;

    logic [SLOT_W-1:0] raddr, waddr;
    logic              ent_we, vld_we;
    flow_entry_t       ent_rd, ent_wr;
    logic              vld_rd, vld_wr;

    trlt_ram #(.WIDTH(ENTRY_W), .DEPTH(FLOW_SLOTS)) u_ent (
        .clk(clk), .we(ent_we), .waddr(waddr), .wdata(ent_wr),
        .raddr(raddr), .rdata(ent_rd)
    );
    trlt_ram #(.WIDTH(1), .DEPTH(FLOW_SLOTS)) u_vld (
        .clk(clk), .we(vld_we), .waddr(waddr), .wdata(vld_wr),
        .raddr(raddr), .rdata(vld_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
        res_reg <= res_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = res_reg;

    logic [KEY_W-1:0] key;
    assign key = {pkt_reg.src_addr, pkt_reg.src_port};

    always_comb
    begin
        logic        over;
        logic        hit;
        logic [63:0] c, s;
        flow_entry_t e;
        pkt_out_t    r;

        state_next = state_reg;
        clr_next   = clr_reg;
        pkt_next   = pkt_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        raddr      = slot_of({in_data.src_addr, in_data.src_port});
        waddr      = slot_of(key);
        ent_we     = 1'b0;
        vld_we     = 1'b0;
        vld_wr     = 1'b0;
        e          = ent_rd;
        r          = '0;
        c          = cnt_reg;
        s          = sum_reg;
        over       = 1'b0;
        hit        = vld_rd && (ent_rd.entry_key == key);

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep one slot per cycle, dropping its valid bit
                waddr    = clr_reg[SLOT_W-1:0];
                vld_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (SLOT_W+1)'(FLOW_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pkt_next   = in_data;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (pkt_reg.syn_flag)
                begin
                    if (!vld_rd)
                    begin
                        e          = '0;
                        e.entry_key = key;
                        e.syn_time = pkt_reg.timestamp_ms;
                        ent_we     = 1'b1;
                        vld_we     = 1'b1;
                        vld_wr     = 1'b1;
                        r.flow_created = 1'b1;
                    end
                    else if (ent_rd.entry_key != key)
                    begin
                        r.flow_dropped = 1'b1;
                    end
                end
                else if (hit)
                begin
                    if ((pkt_reg.ack_num - ent_rd.last_empty_ack) == 32'd1 &&
                        pkt_reg.seq_num == ent_rd.last_empty_seq)
                    begin
                        if (ent_rd.request_start != '0 && ent_rd.response_end != '0)
                        begin
                            r.fin_ack_latency_valid = 1'b1;
                            r.fin_ack_latency_ms =
                                ent_rd.response_end - ent_rd.request_start;
                            c = c + 64'd1;
                            s = s + 64'(r.fin_ack_latency_ms);
                        end
                        over = 1'b1;
                    end
                    if (pkt_reg.rst_flag || pkt_reg.fin_flag)
                    begin
                        if (ent_rd.response_end == '0)
                        begin
                            if (ent_rd.request_start != '0)
                            begin
                                e.response_end = pkt_reg.timestamp_ms;
                                r.other_latency_valid = 1'b1;
                                r.other_latency_ms =
                                    pkt_reg.timestamp_ms - ent_rd.request_start;
                                r.other_latency_kind = KIND_CLOSE_OPEN;
                            end
                        end
                        else if (pkt_reg.ack_num != ent_rd.request_ack)
                        begin
                            r.other_latency_valid = 1'b1;
                            r.other_latency_ms =
                                ent_rd.last_seen - ent_rd.request_start;
                            r.other_latency_kind = KIND_CLOSE_CLOSED;
                        end
                        over = 1'b1;
                    end
                    else
                    begin
                        if (pkt_reg.payload_len != '0)
                        begin
                            if (pkt_reg.ack_num != ent_rd.request_ack)
                            begin
                                if (ent_rd.response_end == '0)
                                begin
                                    if (ent_rd.request_start != '0)
                                    begin
                                        r.other_latency_valid = 1'b1;
                                        r.other_latency_ms = pkt_reg.timestamp_ms -
                                            ent_rd.request_start;
                                        r.other_latency_kind = KIND_NEW_OPEN;
                                    end
                                end
                                else
                                begin
                                    r.other_latency_valid = 1'b1;
                                    r.other_latency_ms =
                                        ent_rd.last_seen - ent_rd.request_start;
                                    r.other_latency_kind = KIND_NEW_CLOSED;
                                end
                                if (!ent_rd.first_request_done)
                                begin
                                    e.first_request_done = 1'b1;
                                    e.request_start = ent_rd.syn_time;
                                end
                                else
                                begin
                                    e.request_start = pkt_reg.timestamp_ms;
                                end
                                e.request_ack = pkt_reg.ack_num;
                            end
                            e.response_end = '0;
                        end
                        else
                        begin
                            e.last_empty_ack = pkt_reg.ack_num;
                            e.last_empty_seq = pkt_reg.seq_num;
                            if (ent_rd.request_start != '0)
                            begin
                                e.response_end = pkt_reg.timestamp_ms;
                            end
                        end
                        e.last_seen = pkt_reg.timestamp_ms;
                    end
                    if (r.other_latency_valid)
                    begin
                        c = c + 64'd1;
                        s = s + 64'(r.other_latency_ms);
                    end
                    ent_we = !over;
                    if (over)
                    begin
                        // drop the flow
                        vld_we = 1'b1;
                        vld_wr = 1'b0;
                        r.flow_closed = 1'b1;
                    end
                end
                r.total_requests = c;
                r.total_time_ms  = s;
                cnt_next   = c;
                sum_next   = s;
                res_next   = r;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ent_wr = e;
    end

    `ASSERT_IMPL(a_ready_out_excl, clk, rst_n, in_ready, !out_valid)
    `ASSERT_NEXT(a_accept_lookup, clk, rst_n, in_valid && in_ready, state_reg == ST_LOOKUP)
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(res_reg))
    `ASSERT_IMPL(a_flag_excl, clk, rst_n, out_valid, !(res_reg.flow_created && (res_reg.flow_closed || res_reg.flow_dropped)))
    `ASSERT_NEXT(a_count_step, clk, rst_n, state_reg == ST_LOOKUP, cnt_reg - $past(cnt_reg) <= 64'd2)

endmodule

[tb/tb.sv]
// Testbench for the TCP request latency tracker: directed flows plus random traffic
`timescale 1ns / 1ps

module tb;
    import trlt_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    pkt_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    pkt_out_t out_data;

    tcp_request_latency_tracker u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Predictor copy of the flow table
    logic              tbl_valid [FLOW_SLOTS];
    logic [KEY_W-1:0]  tbl_key   [FLOW_SLOTS];
    logic              tbl_first [FLOW_SLOTS];
    logic [31:0]       tbl_syn   [FLOW_SLOTS];
    logic [31:0]       tbl_eack  [FLOW_SLOTS];
    logic [31:0]       tbl_eseq  [FLOW_SLOTS];
    logic [31:0]       tbl_rack  [FLOW_SLOTS];
    logic [31:0]       tbl_start [FLOW_SLOTS];
    logic [31:0]       tbl_end   [FLOW_SLOTS];
    logic [31:0]       tbl_seen  [FLOW_SLOTS];
    logic [63:0]       pred_count;
    logic [63:0]       pred_sum;

    pkt_out_t result_queue[$];
    int       err_count;
    int       beats_sent;
    int       beats_checked;
    int       latencies_seen;
    int       stall_left;
    bit       idle_on;

    // Random pool of flows; kept small so flows collide and recur
    logic [31:0] pool_addr [16];
    logic [15:0] pool_port [16];
    logic [31:0] pool_seq  [16];
    logic [31:0] pool_ack  [16];
    logic [31:0] now_ms;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [SLOT_W-1:0] flow_slot(input logic [KEY_W-1:0] key);
        logic [15:0] fold;
        fold = key[15:0] ^ key[31:16] ^ key[47:32];
        return fold[SLOT_W-1:0];
    endfunction

    // Compute the result beat for one packet and advance the flow table
    function automatic pkt_out_t predict_packet(input pkt_in_t p);
        pkt_out_t         r;
        logic [KEY_W-1:0] key;
        logic [SLOT_W-1:0] s;
        logic             over;
        r    = '0;
        key  = {p.src_addr, p.src_port};
        s    = flow_slot(key);
        over = 1'b0;
        if (p.syn_flag)
        begin
            if (!tbl_valid[s])
            begin
                tbl_valid[s] = 1'b1;
                tbl_key[s]   = key;
                tbl_first[s] = 1'b0;
                tbl_syn[s]   = p.timestamp_ms;
                tbl_eack[s]  = '0;
                tbl_eseq[s]  = '0;
                tbl_rack[s]  = '0;
                tbl_start[s] = '0;
                tbl_end[s]   = '0;
                tbl_seen[s]  = '0;
                r.flow_created = 1'b1;
            end
            else if (tbl_key[s] != key)
                r.flow_dropped = 1'b1;
        end
        else if (tbl_valid[s] && tbl_key[s] == key)
        begin
            if (p.ack_num - tbl_eack[s] == 32'd1 && p.seq_num == tbl_eseq[s])
            begin
                if (tbl_start[s] != 0 && tbl_end[s] != 0)
                begin
                    r.fin_ack_latency_valid = 1'b1;
                    r.fin_ack_latency_ms    = tbl_end[s] - tbl_start[s];
                    pred_count += 1;
                    pred_sum   += 64'(r.fin_ack_latency_ms);
                end
                over = 1'b1;
            end
            if (p.rst_flag || p.fin_flag)
            begin
                if (tbl_end[s] == 0)
                begin
                    if (tbl_start[s] != 0)
                    begin
                        tbl_end[s] = p.timestamp_ms;
                        r.other_latency_valid = 1'b1;
                        r.other_latency_ms    = p.timestamp_ms - tbl_start[s];
                        r.other_latency_kind  = KIND_CLOSE_OPEN;
                    end
                end
                else if (p.ack_num != tbl_rack[s])
                begin
                    r.other_latency_valid = 1'b1;
                    r.other_latency_ms    = tbl_seen[s] - tbl_start[s];
                    r.other_latency_kind  = KIND_CLOSE_CLOSED;
                end
                over = 1'b1;
            end
            else
            begin
                if (p.payload_len != 0)
                begin
                    if (p.ack_num != tbl_rack[s])
                    begin
                        if (tbl_end[s] == 0)
                        begin
                            if (tbl_start[s] != 0)
                            begin
                                r.other_latency_valid = 1'b1;
                                r.other_latency_ms    = p.timestamp_ms - tbl_start[s];
                                r.other_latency_kind  = KIND_NEW_OPEN;
                            end
                        end
                        else
                        begin
                            r.other_latency_valid = 1'b1;
                            r.other_latency_ms    = tbl_seen[s] - tbl_start[s];
                            r.other_latency_kind  = KIND_NEW_CLOSED;
                        end
                        if (!tbl_first[s])
                        begin
                            tbl_first[s] = 1'b1;
                            tbl_start[s] = tbl_syn[s];
                        end
                        else
                            tbl_start[s] = p.timestamp_ms;
                        tbl_rack[s] = p.ack_num;
                    end
                    tbl_end[s] = '0;
                end
                else
                begin
                    tbl_eack[s] = p.ack_num;
                    tbl_eseq[s] = p.seq_num;
                    if (tbl_start[s] != 0)
                        tbl_end[s] = p.timestamp_ms;
                end
                tbl_seen[s] = p.timestamp_ms;
            end
            if (r.other_latency_valid)
            begin
                pred_count += 1;
                pred_sum   += 64'(r.other_latency_ms);
            end
            if (over)
            begin
                tbl_valid[s]  = 1'b0;
                r.flow_closed = 1'b1;
            end
        end
        r.total_requests = pred_count;
        r.total_time_ms  = pred_sum;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH beat %0d %s: got %0h expected %0h", beats_checked, what, got, want);
        err_count++;
    endtask

    // Send one packet beat; hold valid and payload until accepted.
    // Valid stays high after the accepting edge unless an idle burst or the drain follows.
    task automatic send_packet(input pkt_in_t p);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        // sample ready between edges, where it is stable
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        result_queue.push_back(predict_packet(p));
        beats_sent++;
    endtask

    // Receiver drops out_ready in random stall bursts while idle_on is set
    always @(posedge clk)
    begin
        if (!rst_n || !idle_on)
        begin
            stall_left = 0;
            out_ready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= (stall_left == 0);
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 11);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Compare each result beat against the oldest prediction; sample between
    // edges, where valid, ready and data show what the next edge takes
    always @(negedge clk)
    begin
        pkt_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_queue.size() == 0)
            begin
                $display("MISMATCH unexpected result beat");
                err_count++;
            end
            else
            begin
                want = result_queue.pop_front();
                if (out_data.fin_ack_latency_valid !== want.fin_ack_latency_valid)
                    report_mismatch("fin_ack_latency_valid", out_data.fin_ack_latency_valid,
                                    want.fin_ack_latency_valid);
                if (out_data.fin_ack_latency_ms !== want.fin_ack_latency_ms)
                    report_mismatch("fin_ack_latency_ms", out_data.fin_ack_latency_ms,
                                    want.fin_ack_latency_ms);
                if (out_data.other_latency_valid !== want.other_latency_valid)
                    report_mismatch("other_latency_valid", out_data.other_latency_valid,
                                    want.other_latency_valid);
                if (out_data.other_latency_ms !== want.other_latency_ms)
                    report_mismatch("other_latency_ms", out_data.other_latency_ms,
                                    want.other_latency_ms);
                if (out_data.other_latency_kind !== want.other_latency_kind)
                    report_mismatch("other_latency_kind", out_data.other_latency_kind,
                                    want.other_latency_kind);
                if (out_data.flow_created !== want.flow_created)
                    report_mismatch("flow_created", out_data.flow_created, want.flow_created);
                if (out_data.flow_closed !== want.flow_closed)
                    report_mismatch("flow_closed", out_data.flow_closed, want.flow_closed);
                if (out_data.flow_dropped !== want.flow_dropped)
                    report_mismatch("flow_dropped", out_data.flow_dropped, want.flow_dropped);
                if (out_data.total_requests !== want.total_requests)
                    report_mismatch("total_requests", out_data.total_requests,
                                    want.total_requests);
                if (out_data.total_time_ms !== want.total_time_ms)
                    report_mismatch("total_time_ms", out_data.total_time_ms, want.total_time_ms);
                latencies_seen += want.fin_ack_latency_valid + want.other_latency_valid;
                beats_checked++;
            end
        end
    end

    function automatic pkt_in_t make_pkt(input logic [31:0] addr, input logic [15:0] port,
                                         input logic [2:0] flags, input logic [31:0] seq,
                                         input logic [31:0] ack, input logic [15:0] plen,
                                         input logic [31:0] ts);
        pkt_in_t p;
        p.src_addr     = addr;
        p.src_port     = port;
        p.syn_flag     = flags[2];
        p.rst_flag     = flags[1];
        p.fin_flag     = flags[0];
        p.seq_num      = seq;
        p.ack_num      = ack;
        p.payload_len  = plen;
        p.timestamp_ms = ts;
        return p;
    endfunction

    // Open a flow, run a request and its response, then close by FIN ack
    task automatic test_request_cycle();
        logic [31:0] a;
        a = 32'h0A000001;
        send_packet(make_pkt(a, 16'd1000, 3'b100, 0, 0, 0, 32'd100));
        send_packet(make_pkt(a, 16'd1000, 3'b000, 1, 500, 16'd40, 32'd110));
        send_packet(make_pkt(a, 16'd1000, 3'b000, 41, 900, 16'd0, 32'd150));
        send_packet(make_pkt(a, 16'd1000, 3'b000, 41, 901, 16'd20, 32'd170));
        send_packet(make_pkt(a, 16'd1000, 3'b000, 61, 1300, 16'd0, 32'd200));
        // FIN after the flow has closed: no latency and no flow flags in the beat
        send_packet(make_pkt(a, 16'd1000, 3'b001, 61, 1301, 16'd0, 32'd210));
    endtask

    // Extremes of fields, SYN collisions, RST close, packets with no flow
    task automatic test_corner_cases();
        send_packet(make_pkt(32'hFFFFFFFF, 16'hFFFF, 3'b111, '1, '1, '1, '1));
        send_packet(make_pkt(32'hFFFFFFFF, 16'hFFFF, 3'b100, 0, 0, 0, 0));
        // same fold, different key: slot held by another flow
        send_packet(make_pkt(32'hFFFF0000, 16'h0000, 3'b100, 0, 0, 0, 32'd5));
        send_packet(make_pkt(32'hFFFF0000, 16'h0000, 3'b000, 0, 0, 16'd9, 32'd5));
        send_packet(make_pkt(32'hFFFFFFFF, 16'hFFFF, 3'b000, 0, '1, '1, '1));
        send_packet(make_pkt(32'hFFFFFFFF, 16'hFFFF, 3'b000, 0, 32'd7, 16'd0, 32'd3));
        send_packet(make_pkt(32'hFFFFFFFF, 16'hFFFF, 3'b010, 0, 32'd8, 16'd0, 32'd2));
        send_packet(make_pkt(32'h00000000, 16'h0000, 3'b011, 0, 0, 0, 0));
        send_packet(make_pkt(32'h00000000, 16'h0000, 3'b100, 0, 0, 0, 32'hFFFFFFFF));
        send_packet(make_pkt(32'h00000000, 16'h0000, 3'b000, 5, 5, 16'd1, 32'd1));
        send_packet(make_pkt(32'h00000000, 16'h0000, 3'b000, 6, 6, 16'd0, 32'd4));
        send_packet(make_pkt(32'h00000000, 16'h0000, 3'b000, 6, 7, 16'd3, 32'd9));
        send_packet(make_pkt(32'h00000000, 16'h0000, 3'b010, 6, 8, 16'd0, 32'd12));
    endtask

    // Random traffic: mostly well-formed conversations over a small flow pool
    task automatic test_random_traffic(input int count);
        pkt_in_t p;
        int      f;
        int      pick;
        for (int n = 0; n < count; n++)
        begin
            f    = $urandom_range(0, 15);
            pick = $urandom_range(0, 99);
            now_ms = now_ms + $urandom_range(0, 50);
            p = make_pkt(pool_addr[f], pool_port[f], 3'b000, pool_seq[f], pool_ack[f], 0,
                         ($urandom_range(0, 15) == 0) ? 32'd0 : now_ms);
            if (pick < 12)
                p.syn_flag = 1'b1;
            else if (pick < 45)
            begin
                p.payload_len = 16'($urandom_range(1, 1500));
                if ($urandom_range(0, 3) != 0)
                    pool_ack[f] += $urandom_range(1, 3000);
                pool_seq[f] += p.payload_len;
                p.ack_num = pool_ack[f];
            end
            else if (pick < 70)
            begin
                // empty ack, sometimes followed by a FIN-ack pattern below
                pool_ack[f] += $urandom_range(0, 2000);
                p.ack_num = pool_ack[f];
            end
            else if (pick < 80)
                p.ack_num = pool_ack[f] + 1;
            else if (pick < 87)
                p.fin_flag = 1'b1;
            else if (pick < 91)
                p.rst_flag = 1'b1;
            else
            begin
                p = pkt_in_t'({7{$urandom}});
                p.src_addr = {$urandom};
                p.seq_num  = {$urandom};
                p.ack_num  = {$urandom};
                p.timestamp_ms = {$urandom};
            end
            send_packet(p);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (result_queue.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        idle_on  = 1'b0;
        err_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        latencies_seen = 0;
        pred_count = '0;
        pred_sum   = '0;
        now_ms     = 32'd1;
        for (int k = 0; k < FLOW_SLOTS; k++)
            tbl_valid[k] = 1'b0;
        for (int k = 0; k < 16; k++)
        begin
            pool_addr[k] = $urandom;
            pool_port[k] = 16'($urandom);
            pool_seq[k]  = $urandom;
            pool_ack[k]  = $urandom;
        end
        // force pool flow 1 onto the same slot as pool flow 0
        pool_addr[1] = pool_addr[0];
        pool_port[1] = pool_port[0] ^ 16'h1000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_request_cycle();
        test_corner_cases();
        idle_on = 1'b1;
        test_random_traffic(1700);
        idle_on = 1'b0;
        test_random_traffic(300);
        wait_drained();
        $display("Checked %0d of %0d result beats, %0d latencies recorded.",
                 beats_checked, beats_sent, latencies_seen);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout");
        $display("Test completed with failures");
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/trlt_pkg.sv
hw/rtl/trlt_ram.sv
hw/rtl/tcp_request_latency_tracker.sv
tb/tb.sv
